@@ hw/rtl/spd_pkg.sv @@
// Shared constants, types and the sequencer program for the segment proximity block.
// No dependencies; used by spd_mac and segment_proximity_dedup_top.
package spd_pkg;

    localparam int COORD_BITS = 32;
    localparam int FIELD_W    = 32;
    localparam int RAD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int LIMB_W     = COORD_BITS + 1;
    localparam int WIDE_W     = 2 * LIMB_W;
    localparam int MUL_W      = (LIMB_W > 2 * RAD_W) ? LIMB_W : 2 * RAD_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = PROD_W + 2 * LIMB_W + 2;
    localparam int MAG_W      = ACC_W - 1;
    localparam int PC_W       = 6;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QAZ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QBX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QBY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QBZ    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd6;

    // micro-op kinds
    localparam logic [2:0] K_MAC    = 3'd0;
    localparam logic [2:0] K_STORE  = 3'd1;
    localparam logic [2:0] K_PBEGIN = 3'd2;
    localparam logic [2:0] K_CMPLIM = 3'd3;
    localparam logic [2:0] K_YMAX   = 3'd4;
    localparam logic [2:0] K_YSEL   = 3'd5;
    localparam logic [2:0] K_YFIN   = 3'd6;

    // multiplier operand sources
    localparam logic [4:0] S_V0  = 5'd0;
    localparam logic [4:0] S_V1  = 5'd1;
    localparam logic [4:0] S_V2  = 5'd2;
    localparam logic [4:0] S_DS0 = 5'd3;
    localparam logic [4:0] S_DS1 = 5'd4;
    localparam logic [4:0] S_DS2 = 5'd5;
    localparam logic [4:0] S_DE0 = 5'd6;
    localparam logic [4:0] S_DE1 = 5'd7;
    localparam logic [4:0] S_DE2 = 5'd8;
    localparam logic [4:0] S_T0L = 5'd9;
    localparam logic [4:0] S_T0H = 5'd10;
    localparam logic [4:0] S_T1L = 5'd11;
    localparam logic [4:0] S_T1H = 5'd12;
    localparam logic [4:0] S_T2L = 5'd13;
    localparam logic [4:0] S_T2H = 5'd14;
    localparam logic [4:0] S_YL  = 5'd15;
    localparam logic [4:0] S_YH  = 5'd16;
    localparam logic [4:0] S_L2L = 5'd17;
    localparam logic [4:0] S_L2H = 5'd18;
    localparam logic [4:0] S_R   = 5'd19;
    localparam logic [4:0] S_R2  = 5'd20;

    // store targets
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_L2   = 4'd1;
    localparam logic [3:0] D_R2   = 4'd2;
    localparam logic [3:0] D_LIM  = 4'd3;
    localparam logic [3:0] D_T0   = 4'd4;
    localparam logic [3:0] D_T1   = 4'd5;
    localparam logic [3:0] D_T2   = 4'd6;
    localparam logic [3:0] D_C    = 4'd7;
    localparam logic [3:0] D_D1   = 4'd8;
    localparam logic [3:0] D_D2   = 4'd9;

    // product alignment in limbs
    localparam logic [1:0] SH0 = 2'd0;
    localparam logic [1:0] SH1 = 2'd1;
    localparam logic [1:0] SH2 = 2'd2;

    localparam logic [PC_W-1:0] PC_POINT = 6'd9;
    localparam logic [PC_W-1:0] PC_LAST  = 6'd47;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [1:0] shift;
        logic       neg;
        logic [3:0] dest;
    } uop_t;

    typedef struct packed {
        logic             issue;
        logic             clr;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
        logic             neg;
        logic [1:0]       shift;
    } mac_ctl_t;

    function automatic uop_t mk(input logic [2:0] kind, input logic [4:0] a,
                                input logic [4:0] b, input logic [1:0] sh,
                                input logic neg, input logic [3:0] dest);
        uop_t u;
        u.kind  = kind;
        u.src_a = a;
        u.src_b = b;
        u.shift = sh;
        u.neg   = neg;
        u.dest  = dest;
        return u;
    endfunction

    function automatic uop_t mac(input logic [4:0] a, input logic [4:0] b,
                                 input logic [1:0] sh, input logic neg);
        return mk(K_MAC, a, b, sh, neg, D_NONE);
    endfunction

    function automatic uop_t ctl(input logic [2:0] kind, input logic [3:0] dest);
        return mk(kind, S_V0, S_V0, SH0, 1'b0, dest);
    endfunction

    // Program: per-item setup, then the point test run once per query point.
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mac(S_V0, S_V0, SH0, 1'b0);
            6'd1:  u = mac(S_V1, S_V1, SH0, 1'b0);
            6'd2:  u = mac(S_V2, S_V2, SH0, 1'b0);
            6'd3:  u = ctl(K_STORE, D_L2);
            6'd4:  u = mac(S_R, S_R, SH0, 1'b0);
            6'd5:  u = ctl(K_STORE, D_R2);
            6'd6:  u = mac(S_R2, S_L2L, SH0, 1'b0);
            6'd7:  u = mac(S_R2, S_L2H, SH1, 1'b0);
            6'd8:  u = ctl(K_STORE, D_LIM);
            6'd9:  u = ctl(K_PBEGIN, D_NONE);
            6'd10: u = mac(S_DS0, S_V1, SH0, 1'b0);
            6'd11: u = mac(S_DS1, S_V0, SH0, 1'b1);
            6'd12: u = ctl(K_STORE, D_T0);
            6'd13: u = mac(S_DS1, S_V2, SH0, 1'b0);
            6'd14: u = mac(S_DS2, S_V1, SH0, 1'b1);
            6'd15: u = ctl(K_STORE, D_T1);
            6'd16: u = mac(S_DS2, S_V0, SH0, 1'b0);
            6'd17: u = mac(S_DS0, S_V2, SH0, 1'b1);
            6'd18: u = ctl(K_STORE, D_T2);
            6'd19: u = mac(S_T0L, S_T0L, SH0, 1'b0);
            6'd20: u = mac(S_T0L, S_T0H, SH1, 1'b0);
            6'd21: u = mac(S_T0L, S_T0H, SH1, 1'b0);
            6'd22: u = mac(S_T0H, S_T0H, SH2, 1'b0);
            6'd23: u = mac(S_T1L, S_T1L, SH0, 1'b0);
            6'd24: u = mac(S_T1L, S_T1H, SH1, 1'b0);
            6'd25: u = mac(S_T1L, S_T1H, SH1, 1'b0);
            6'd26: u = mac(S_T1H, S_T1H, SH2, 1'b0);
            6'd27: u = mac(S_T2L, S_T2L, SH0, 1'b0);
            6'd28: u = mac(S_T2L, S_T2H, SH1, 1'b0);
            6'd29: u = mac(S_T2L, S_T2H, SH1, 1'b0);
            6'd30: u = mac(S_T2H, S_T2H, SH2, 1'b0);
            6'd31: u = ctl(K_STORE, D_C);
            6'd32: u = ctl(K_CMPLIM, D_NONE);
            6'd33: u = mac(S_DS0, S_V0, SH0, 1'b0);
            6'd34: u = mac(S_DS1, S_V1, SH0, 1'b0);
            6'd35: u = mac(S_DS2, S_V2, SH0, 1'b0);
            6'd36: u = ctl(K_STORE, D_D1);
            6'd37: u = mac(S_DE0, S_V0, SH0, 1'b0);
            6'd38: u = mac(S_DE1, S_V1, SH0, 1'b0);
            6'd39: u = mac(S_DE2, S_V2, SH0, 1'b0);
            6'd40: u = ctl(K_STORE, D_D2);
            6'd41: u = ctl(K_YMAX, D_NONE);
            6'd42: u = ctl(K_YSEL, D_NONE);
            6'd43: u = mac(S_YL, S_YL, SH0, 1'b0);
            6'd44: u = mac(S_YL, S_YH, SH1, 1'b0);
            6'd45: u = mac(S_YL, S_YH, SH1, 1'b0);
            6'd46: u = mac(S_YH, S_YH, SH2, 1'b0);
            6'd47: u = ctl(K_YFIN, D_NONE);
            default: u = ctl(K_YFIN, D_NONE);
        endcase
        return u;
    endfunction

    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    endfunction

    // magnitude of a coordinate difference always fits COORD_BITS bits
    function automatic logic [COORD_BITS-1:0] dmag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] n;
        n = d[DIFF_W-1] ? (~d + 1'b1) : d;
        return n[COORD_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/spd_mac.sv @@
// Shared multiply-accumulate unit: one registered product, then a signed wide accumulate.
// Depends on spd_pkg.
module spd_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spd_pkg::mac_ctl_t                   ctl,
    output logic signed [spd_pkg::ACC_W-1:0]    acc,
    output logic                                pend
);

    logic [spd_pkg::PROD_W-1:0]       prod_reg;
    logic                             neg_reg;
    logic [1:0]                       shift_reg;
    logic                             pend_reg;
    logic signed [spd_pkg::ACC_W-1:0] acc_reg;
    logic signed [spd_pkg::ACC_W-1:0] acc_next;
    logic [spd_pkg::ACC_W-1:0]        term;

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg  <= ctl.a * ctl.b;
            neg_reg   <= ctl.neg;
            shift_reg <= ctl.shift;
        end
    end

    always_comb
    begin
        case (shift_reg)
            spd_pkg::SH0: term = spd_pkg::ACC_W'(prod_reg);
            spd_pkg::SH1: term = spd_pkg::ACC_W'(prod_reg) << spd_pkg::LIMB_W;
            spd_pkg::SH2: term = spd_pkg::ACC_W'(prod_reg) << (2 * spd_pkg::LIMB_W);
            default:      term = '0;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
            acc_next = '0;
        else if (pend_reg)
            acc_next = neg_reg ? (acc_reg - $signed(term)) : (acc_reg + $signed(term));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            pend_reg <= ctl.issue;
            acc_reg  <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign pend = pend_reg;

endmodule

@@ hw/rtl/segment_proximity_dedup_top.sv @@
// Segment proximity test against two query points, with sticky near flags per scan.
// Depends on spd_pkg and spd_mac.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid/in_ready   | start_x/y/z, end_x/y/z, last_segment
//  out     | output    | out_valid/out_ready | near_a, near_b, duplicate
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The sequencer runs a short program for a segment when both points are already found and the
// full program when both are fully tested; a new segment is taken only after the last one's
// result is loaded. The single 33x33 multiplier, issued by the microcode sequencer, sets the
// run time. in_ready is high only while the sequencer idles.
// A finished result sits in the output register, so the next segment can be taken while it
// waits. Reset clears the flags and loads radius 20 and zero query points; cfg_ready is high.
module segment_proximity_dedup_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spd_pkg::FIELD_W-1:0]       start_x,
    input  logic [spd_pkg::FIELD_W-1:0]       start_y,
    input  logic [spd_pkg::FIELD_W-1:0]       start_z,
    input  logic [spd_pkg::FIELD_W-1:0]       end_x,
    input  logic [spd_pkg::FIELD_W-1:0]       end_y,
    input  logic [spd_pkg::FIELD_W-1:0]       end_z,
    input  logic                              last_segment,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              near_a,
    output logic                              near_b,
    output logic                              duplicate,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spd_pkg::FIELD_W-1:0]       cfg_data
);

    localparam int CB = spd_pkg::COORD_BITS;
    localparam int LW = spd_pkg::LIMB_W;
    localparam int WW = spd_pkg::WIDE_W;
    localparam int MW = spd_pkg::MUL_W;
    localparam int GW = spd_pkg::MAG_W;
    localparam int R2W = 2 * spd_pkg::RAD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [spd_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     pt_reg, pt_next;
    logic                     found_a_reg, found_a_next;
    logic                     found_b_reg, found_b_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     near_a_reg, near_b_reg, dup_reg;

    logic [CB-1:0]                 s_reg [3];
    logic [CB-1:0]                 e_reg [3];
    logic [CB-1:0]                 qa_reg [3];
    logic [CB-1:0]                 qb_reg [3];
    logic                          last_reg;
    logic [spd_pkg::RAD_W-1:0]     radius_reg;

    logic [WW-1:0]  l2_reg;
    logic [R2W-1:0] r2_reg;
    logic [GW-1:0]  lim_reg;
    logic [WW-1:0]  t_reg [3];
    logic [GW-1:0]  c_reg;
    logic [WW-1:0]  d1_reg, d2_reg, y_reg;

    spd_pkg::uop_t                    uop;
    spd_pkg::mac_ctl_t                mac_ctl;
    logic signed [spd_pkg::ACC_W-1:0] acc;
    logic                             mac_pend;
    logic [spd_pkg::ACC_W-1:0]        acc_neg;
    logic [GW-1:0]                    acc_mag;

    logic [CB-1:0]                    p [3];
    logic signed [spd_pkg::DIFF_W-1:0] v [3];
    logic signed [spd_pkg::DIFF_W-1:0] ds [3];
    logic signed [spd_pkg::DIFF_W-1:0] de [3];
    logic [MW-1:0]                    src_mag [32];
    logic                             src_sgn [32];

    logic exec, in_acc, pt_done, pt_near, pt_found, degen, p_eq_s, out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign near_a    = near_a_reg;
    assign near_b    = near_b_reg;
    assign duplicate = dup_reg;

    assign uop  = spd_pkg::ucode(pc_reg);
    // hold a non-multiply step until the last product has landed in the accumulator
    assign exec = (state_reg == ST_RUN) && !(mac_pend && (uop.kind != spd_pkg::K_MAC));

    assign acc_neg = ~acc + 1'b1;
    assign acc_mag = acc[spd_pkg::ACC_W-1] ? acc_neg[GW-1:0] : acc[GW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p[i]  = pt_reg ? qb_reg[i] : qa_reg[i];
            v[i]  = spd_pkg::diff(e_reg[i], s_reg[i]);
            ds[i] = spd_pkg::diff(p[i], s_reg[i]);
            de[i] = spd_pkg::diff(p[i], e_reg[i]);
        end
        degen = (e_reg[0] == s_reg[0]) && (e_reg[1] == s_reg[1]) && (e_reg[2] == s_reg[2]);
        p_eq_s = (p[0] == s_reg[0]) && (p[1] == s_reg[1]) && (p[2] == s_reg[2]);
    end

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            src_mag[i] = '0;
            src_sgn[i] = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            src_mag[spd_pkg::S_V0 + i]  = MW'(spd_pkg::dmag(v[i]));
            src_sgn[spd_pkg::S_V0 + i]  = v[i][spd_pkg::DIFF_W-1];
            src_mag[spd_pkg::S_DS0 + i] = MW'(spd_pkg::dmag(ds[i]));
            src_sgn[spd_pkg::S_DS0 + i] = ds[i][spd_pkg::DIFF_W-1];
            src_mag[spd_pkg::S_DE0 + i] = MW'(spd_pkg::dmag(de[i]));
            src_sgn[spd_pkg::S_DE0 + i] = de[i][spd_pkg::DIFF_W-1];
            src_mag[spd_pkg::S_T0L + 2 * i] = MW'(t_reg[i][LW-1:0]);
            src_mag[spd_pkg::S_T0H + 2 * i] = MW'(t_reg[i][WW-1:LW]);
        end
        src_mag[spd_pkg::S_YL]  = MW'(y_reg[LW-1:0]);
        src_mag[spd_pkg::S_YH]  = MW'(y_reg[WW-1:LW]);
        src_mag[spd_pkg::S_L2L] = MW'(l2_reg[LW-1:0]);
        src_mag[spd_pkg::S_L2H] = MW'(l2_reg[WW-1:LW]);
        src_mag[spd_pkg::S_R]   = MW'(radius_reg);
        src_mag[spd_pkg::S_R2]  = MW'(r2_reg);
    end

    always_comb
    begin
        mac_ctl.issue = exec && (uop.kind == spd_pkg::K_MAC);
        mac_ctl.clr   = exec && (uop.kind != spd_pkg::K_MAC);
        mac_ctl.a     = src_mag[uop.src_a];
        mac_ctl.b     = src_mag[uop.src_b];
        mac_ctl.neg   = uop.neg ^ src_sgn[uop.src_a] ^ src_sgn[uop.src_b];
        mac_ctl.shift = uop.shift;
    end

    spd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .acc   (acc),
        .pend  (mac_pend)
    );

    always_comb
    begin
        pt_found = pt_reg ? found_b_reg : found_a_reg;
        pt_done  = 1'b0;
        pt_near  = 1'b0;
        case (uop.kind)
            spd_pkg::K_PBEGIN:
            begin
                if (pt_found || degen)
                begin
                    pt_done = 1'b1;
                    pt_near = !pt_found && p_eq_s;
                end
            end
            spd_pkg::K_CMPLIM:
                pt_done = (c_reg > lim_reg);
            spd_pkg::K_YSEL:
            begin
                if (y_reg <= l2_reg)
                begin
                    pt_done = 1'b1;
                    pt_near = 1'b1;
                end
            end
            spd_pkg::K_YFIN:
            begin
                pt_done = 1'b1;
                pt_near = (acc_mag <= GW'(l2_reg));
            end
            default:
                pt_done = 1'b0;
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        pt_next        = pt_reg;
        found_a_next   = found_a_reg;
        found_b_next   = found_b_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                    pt_next    = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (exec)
                begin
                    if (pt_done)
                    begin
                        if (pt_near && !pt_reg)
                            found_a_next = 1'b1;
                        if (pt_near && pt_reg)
                            found_b_next = 1'b1;
                        if (!pt_reg)
                        begin
                            pt_next = 1'b1;
                            pc_next = spd_pkg::PC_POINT;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    // drop the flags once the last segment of the scan is reported
                    if (last_reg)
                    begin
                        found_a_next = 1'b0;
                        found_b_next = 1'b0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            pt_reg        <= 1'b0;
            found_a_reg   <= 1'b0;
            found_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            pt_reg        <= pt_next;
            found_a_reg   <= found_a_next;
            found_b_reg   <= found_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qa_reg[i] <= '0;
                qb_reg[i] <= '0;
            end
            radius_reg <= spd_pkg::RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spd_pkg::REG_QAX:    qa_reg[0]  <= cfg_data[CB-1:0];
                spd_pkg::REG_QAY:    qa_reg[1]  <= cfg_data[CB-1:0];
                spd_pkg::REG_QAZ:    qa_reg[2]  <= cfg_data[CB-1:0];
                spd_pkg::REG_QBX:    qb_reg[0]  <= cfg_data[CB-1:0];
                spd_pkg::REG_QBY:    qb_reg[1]  <= cfg_data[CB-1:0];
                spd_pkg::REG_QBZ:    qb_reg[2]  <= cfg_data[CB-1:0];
                spd_pkg::REG_RADIUS: radius_reg <= cfg_data[spd_pkg::RAD_W-1:0];
                default:             radius_reg <= radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s_reg[0] <= start_x[CB-1:0];
            s_reg[1] <= start_y[CB-1:0];
            s_reg[2] <= start_z[CB-1:0];
            e_reg[0] <= end_x[CB-1:0];
            e_reg[1] <= end_y[CB-1:0];
            e_reg[2] <= end_z[CB-1:0];
            last_reg <= last_segment;
        end
        if (out_load)
        begin
            near_a_reg <= found_a_reg;
            near_b_reg <= found_b_reg;
            dup_reg    <= found_a_reg && found_b_reg;
        end
        if (exec)
        begin
            case (uop.kind)
                spd_pkg::K_STORE:
                begin
                    case (uop.dest)
                        spd_pkg::D_L2:  l2_reg   <= acc_mag[WW-1:0];
                        spd_pkg::D_R2:  r2_reg   <= acc_mag[R2W-1:0];
                        spd_pkg::D_LIM: lim_reg  <= acc_mag;
                        spd_pkg::D_T0:  t_reg[0] <= acc_mag[WW-1:0];
                        spd_pkg::D_T1:  t_reg[1] <= acc_mag[WW-1:0];
                        spd_pkg::D_T2:  t_reg[2] <= acc_mag[WW-1:0];
                        spd_pkg::D_C:   c_reg    <= acc_mag;
                        spd_pkg::D_D1:  d1_reg   <= acc_mag[WW-1:0];
                        spd_pkg::D_D2:  d2_reg   <= acc_mag[WW-1:0];
                        default:        c_reg    <= c_reg;
                    endcase
                end
                spd_pkg::K_YMAX:
                    y_reg <= (d1_reg >= d2_reg) ? d1_reg : d2_reg;
                spd_pkg::K_YSEL:
                    y_reg <= y_reg - l2_reg;
                default:
                    y_reg <= y_reg;
            endcase
        end
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= spd_pkg::PC_LAST)
        else $error("sequencer ran past the end of the program");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mac_pend)
        else $error("product still in flight while idle");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (found_a_reg && (state_reg != ST_DONE)) |=> found_a_reg)
        else $error("near flag dropped before the end of the scan");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> (!found_a_reg && !found_b_reg && out_valid_reg))
        else $error("flags not cleared after the last segment");

endmodule

@@ tb/segment_proximity_dedup_top_test.sv @@
// Self-checking testbench for segment_proximity_dedup_top: exact integer predictor of the
// near/duplicate flags, random handshake gaps on the in and out channels. Depends on spd_pkg and the RTL.
module segment_proximity_dedup_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic [31:0] sx, sy, sz, ex, ey, ez;
        logic        last;
    } segment_t;

    typedef struct {
        logic a, b, dup;
    } flags_t;

    // index past the register list, written to check that it is ignored
    localparam logic [spd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic last_segment = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic near_a, near_b, duplicate;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [spd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor copy of registers and sticky flags
    logic signed [31:0] qa [3];
    logic signed [31:0] qb [3];
    logic [15:0] rad_q;
    logic seen_a, seen_b;

    flags_t expected_flags [$];
    int errors = 0;
    int segs_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    longint cycles = 0;
    bit calm = 0;

    segment_proximity_dedup_top uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls
    int stall = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else if (stall > 0)
        begin
            out_ready = 1'b0;
            stall--;
        end
        else
        begin
            out_ready = 1'b1;
            stall = gap_len();
        end
    end

    always @(posedge clk)
    begin
        flags_t x;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_flags.size() == 0)
            begin
                $error("result with no segment pending: near_a=%0b near_b=%0b duplicate=%0b",
                       near_a, near_b, duplicate);
                errors++;
            end
            else
            begin
                x = expected_flags.pop_front();
                if (near_a !== x.a)
                begin
                    $error("near_a expected %0b actual %0b", x.a, near_a);
                    errors++;
                end
                if (near_b !== x.b)
                begin
                    $error("near_b expected %0b actual %0b", x.b, near_b);
                    errors++;
                end
                if (duplicate !== x.dup)
                begin
                    $error("duplicate expected %0b actual %0b", x.dup, duplicate);
                    errors++;
                end
            end
        end
    end

    function automatic wide_t absw(wide_t x);
        return x < 0 ? -x : x;
    endfunction

    // exact proximity test of point p against segment s..e
    function automatic logic point_near(logic signed [31:0] p [3], segment_t g);
        wide_t s [3], e [3], v [3], ds [3], de [3];
        wide_t l2, c, lim, t0, t1, t2, d1, d2, m, y;
        s[0] = $signed(g.sx); s[1] = $signed(g.sy); s[2] = $signed(g.sz);
        e[0] = $signed(g.ex); e[1] = $signed(g.ey); e[2] = $signed(g.ez);
        for (int i = 0; i < 3; i++)
        begin
            v[i] = e[i] - s[i];
            ds[i] = wide_t'(p[i]) - s[i];
            de[i] = wide_t'(p[i]) - e[i];
        end
        if (v[0] == 0 && v[1] == 0 && v[2] == 0)
            return ds[0] == 0 && ds[1] == 0 && ds[2] == 0;
        l2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        t0 = ds[0] * v[1] - ds[1] * v[0];
        t1 = ds[1] * v[2] - ds[2] * v[1];
        t2 = ds[2] * v[0] - ds[0] * v[2];
        c = t0 * t0 + t1 * t1 + t2 * t2;
        lim = wide_t'(rad_q) * wide_t'(rad_q) * l2;
        if (c > lim)
            return 1'b0;
        d1 = absw(ds[0] * v[0] + ds[1] * v[1] + ds[2] * v[2]);
        d2 = absw(de[0] * v[0] + de[1] * v[1] + de[2] * v[2]);
        m = d1 >= d2 ? d1 : d2;
        if (m <= l2)
            return 1'b1;
        y = m - l2;
        return y * y <= l2;
    endfunction

    function automatic void predict_flags(segment_t g);
        flags_t x;
        if (!seen_a && point_near(qa, g))
            seen_a = 1'b1;
        if (!seen_b && point_near(qb, g))
            seen_b = 1'b1;
        x.a = seen_a;
        x.b = seen_b;
        x.dup = seen_a && seen_b;
        expected_flags.push_back(x);
        if (g.last)
        begin
            seen_a = 1'b0;
            seen_b = 1'b0;
        end
    endfunction

    task automatic send_segment(segment_t g);
        repeat (gap_len()) @(negedge clk);
        start_x = g.sx; start_y = g.sy; start_z = g.sz;
        end_x = g.ex; end_y = g.ey; end_z = g.ez;
        last_segment = g.last;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_flags(g);
        segs_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= spd_pkg::REG_QAZ)
            qa[idx[1:0]] = data;
        else if (idx <= spd_pkg::REG_QBZ)
            qb[2'(idx - spd_pkg::REG_QBX)] = data;
        else if (idx == spd_pkg::REG_RADIUS)
            rad_q = data[15:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for all results, then let the sequencer settle
    task automatic drain();
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_queries(logic [31:0] ax, ay, az, bx, by, bz, logic [15:0] r);
        write_reg(spd_pkg::REG_QAX, ax);
        write_reg(spd_pkg::REG_QAY, ay);
        write_reg(spd_pkg::REG_QAZ, az);
        write_reg(spd_pkg::REG_QBX, bx);
        write_reg(spd_pkg::REG_QBY, by);
        write_reg(spd_pkg::REG_QBZ, bz);
        write_reg(spd_pkg::REG_RADIUS, {16'($urandom), r});
    endtask

    function automatic segment_t mk_seg(int sx, sy, sz, ex, ey, ez, logic last);
        segment_t g;
        g.sx = sx; g.sy = sy; g.sz = sz;
        g.ex = ex; g.ey = ey; g.ez = ez;
        g.last = last;
        return g;
    endfunction

    function automatic logic [31:0] jitter(logic [31:0] base, int span);
        return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        calm = 1;
        // radius 20 and both points at origin out of reset
        send_segment(mk_seg(0, 0, 0, 0, 0, 0, 1'b0));
        send_segment(mk_seg(5, 0, 0, 5, 0, 0, 1'b1));
        send_segment(mk_seg(-100, 20, 0, 100, 20, 0, 1'b0));
        send_segment(mk_seg(-100, 21, 0, 100, 21, 0, 1'b1));
        send_segment(mk_seg(1, 0, 0, 10, 0, 0, 1'b0));
        send_segment(mk_seg(2, 0, 0, 10, 0, 0, 1'b1));
        drain();
    endtask

    task automatic test_sticky_and_extremes();
        set_queries(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        send_segment(mk_seg(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
        send_segment(mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        send_segment(mk_seg(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
        send_segment(mk_seg(0, 0, 0, 0, 0, 0, 1'b1));
        send_segment(mk_seg(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 1'b1));
        drain();
        set_queries(0, 0, 0, 3, 4, 0, 16'd0);
        send_segment(mk_seg(-5, 0, 0, 5, 0, 0, 1'b0));
        send_segment(mk_seg(3, 4, 0, 3, 4, 0, 1'b0));
        send_segment(mk_seg(3, 4, 1, 3, 4, 1, 1'b1));
        send_segment(mk_seg(3, 0, 0, 9, 0, 0, 1'b1));
        send_segment(mk_seg(-6, 8, 0, 0, 0, 0, 1'b1));
        drain();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_segment(mk_seg(1, 0, 0, 2, 0, 0, 1'b1));
        drain();
    endtask

    task automatic test_random_scans(int phases, int per_phase);
        segment_t g;
        logic [31:0] pa [3], pb [3];
        logic [15:0] r;
        int left, span;
        for (int ph = 0; ph < phases; ph++)
        begin
            calm = (ph % 3 == 2);
            for (int i = 0; i < 3; i++)
            begin
                pa[i] = any_coord();
                pb[i] = ($urandom_range(0, 1)) ? jitter(pa[i], 200) : any_coord();
            end
            case (ph % 4)
                0: r = 16'd0;
                1: r = 16'hffff;
                default: r = $urandom_range(0, 100);
            endcase
            set_queries(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2], r);
            left = per_phase;
            while (left > 0)
            begin
                int scan;
                scan = $urandom_range(1, 8);
                for (int k = 0; k < scan && left > 0; k++, left--)
                begin
                    span = ($urandom_range(0, 3) == 0) ? 100000 : 60;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3:
                            g = mk_seg(jitter(pa[0], span), jitter(pa[1], span),
                                       jitter(pa[2], span), jitter(pa[0], span),
                                       jitter(pa[1], span), jitter(pa[2], span), 1'b0);
                        4, 5, 6:
                            g = mk_seg(jitter(pb[0], span), jitter(pb[1], span),
                                       jitter(pb[2], span), jitter(pb[0], span),
                                       jitter(pb[1], span), jitter(pb[2], span), 1'b0);
                        7:
                        begin
                            g = mk_seg(jitter(pa[0], 2), jitter(pa[1], 2), jitter(pa[2], 2),
                                       0, 0, 0, 1'b0);
                            g.ex = g.sx; g.ey = g.sy; g.ez = g.sz;
                        end
                        default:
                            g = mk_seg(any_coord(), any_coord(), any_coord(),
                                       any_coord(), any_coord(), any_coord(), 1'b0);
                    endcase
                    // last_segment mostly ends a scan, now and then stray
                    g.last = (k == scan - 1) || ($urandom_range(0, 30) == 0);
                    send_segment(g);
                end
            end
            drain();
        end
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            qa[i] = '0;
            qb[i] = '0;
        end
        rad_q = spd_pkg::RADIUS_RESET;
        seen_a = 1'b0;
        seen_b = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_sticky_and_extremes();
        test_random_scans(6, 115);
        $display("covered %0d segments, %0d results, %0d register writes",
                 segs_sent, results_seen, cfg_writes);
        $display("radius 0 and 65535, extreme coordinates, degenerate and sticky scans");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/spd_pkg.sv
hw/rtl/spd_mac.sv
hw/rtl/segment_proximity_dedup_top.sv
tb/segment_proximity_dedup_top_test.sv
